@@ sv/ccrc_pkg.sv @@
// ----------------------------------------------------------------------------
// Colour contrast ratio check package
// Shared constants, register codes and the fifth-root helper used to build
// the sRGB linearisation table at elaboration.
// ----------------------------------------------------------------------------
package ccrc_pkg;

  localparam int WQ         = 30;
  localparam int WEIGHT_W   = 16;
  localparam int RATIO_W    = 13;
  localparam int RATIO_FRAC = 8;
  localparam int QUO_W      = 13;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [WEIGHT_W-1:0] W_RED   = 16'd13933;
  localparam logic [WEIGHT_W-1:0] W_GREEN = 16'd46871;
  localparam logic [WEIGHT_W-1:0] W_BLUE  = 16'd4732;

  localparam logic [RATIO_W-1:0] MIN_RATIO_RST = 13'd1152;

  typedef enum logic {
    REG_MIN_RATIO    = 1'b0,
    REG_MIN_LUM_DIFF = 1'b1
  } reg_idx_e;

  function automatic logic [63:0] pow5_q30(input logic [63:0] w);
    logic [63:0] p;
    p = w;
    for (int i = 0; i < 4; i++) begin
      p = (p * w) >> WQ;
    end
    return p;
  endfunction

  function automatic logic [63:0] root5_q30(input logic [63:0] y2);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = 64'd0;
    hi = 64'd1 << WQ;
    for (int i = 0; i < WQ + 2; i++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (pow5_q30(mid) <= y2) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return lo;
  endfunction

endpackage

@@ sv/ccrc_lum_lane.sv @@
// ----------------------------------------------------------------------------
// Luminance lane
// Linearises one RGB colour through the sRGB table and forms the weighted,
// rounded relative luminance over three pipeline stages.
// ----------------------------------------------------------------------------
module ccrc_lum_lane
  import ccrc_pkg::*;
#(
  parameter int CHANNEL_BITS  = 8,
  parameter int LUM_FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic [2:0]               en_i,
  input  logic [CHANNEL_BITS-1:0]  red_i,
  input  logic [CHANNEL_BITS-1:0]  green_i,
  input  logic [CHANNEL_BITS-1:0]  blue_i,
  output logic [LUM_FRAC_BITS:0]   lum_o
);

  localparam int LW  = LUM_FRAC_BITS + 1;
  localparam int PW  = LW + WEIGHT_W;
  localparam int SW  = PW + 2;
  localparam int TBL = 1 << CHANNEL_BITS;
  localparam logic [63:0] CH_MAX = (64'd1 << CHANNEL_BITS) - 64'd1;

  logic [LW-1:0] lin_tbl [TBL];

  for (genvar c = 0; c < TBL; c++) begin : g_tbl
    localparam logic [63:0] CV     = 64'(c);
    localparam logic [63:0] DEN_LO = 64'd1292 * CH_MAX;
    localparam logic [63:0] X_LO   = ((CV * 64'd100) << LUM_FRAC_BITS) + DEN_LO / 64'd2;
    localparam logic [63:0] E_LO   = (X_LO[31:0] == 32'd0) ? 64'd0 : X_LO / DEN_LO;
    localparam logic [63:0] DEN_HI = 64'd1055 * CH_MAX;
    localparam logic [63:0] NUM_HI = 64'd1000 * CV + 64'd55 * CH_MAX;
    localparam logic [63:0] Y      = ((NUM_HI << WQ) + DEN_HI / 64'd2) / DEN_HI;
    localparam logic [63:0] Y2     = (Y * Y + (64'd1 << (WQ - 1))) >> WQ;
    localparam logic [63:0] W5     = root5_q30(Y2);
    localparam logic [63:0] E_HI   = (Y2 * W5 + (64'd1 << (2 * WQ - 1 - LUM_FRAC_BITS)))
                                     >> (2 * WQ - LUM_FRAC_BITS);
    localparam logic [63:0] ENT    = (CV * 64'd100000 <= 64'd3928 * CH_MAX) ?
                                     {32'd0, E_LO[31:0]} : {32'd0, E_HI[31:0]};
    assign lin_tbl[c] = ENT[LW-1:0];
  end

  logic [LW-1:0] lin_r_q, lin_g_q, lin_b_q;
  logic [PW-1:0] prod_r_q, prod_g_q, prod_b_q;
  logic [LW-1:0] lum_q;
  logic [SW-1:0] sum;

  assign sum = SW'(prod_r_q) + SW'(prod_g_q) + SW'(prod_b_q) + SW'(32768);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      lin_r_q <= lin_tbl[red_i];
      lin_g_q <= lin_tbl[green_i];
      lin_b_q <= lin_tbl[blue_i];
    end
    if (en_i[1]) begin
      prod_r_q <= PW'(lin_r_q) * PW'(W_RED);
      prod_g_q <= PW'(lin_g_q) * PW'(W_GREEN);
      prod_b_q <= PW'(lin_b_q) * PW'(W_BLUE);
    end
    if (en_i[2]) begin
      lum_q <= sum[WEIGHT_W +: LW];
    end
  end

  assign lum_o = lum_q;

endmodule

@@ sv/ccrc_merge.sv @@
// ----------------------------------------------------------------------------
// Lane merge
// Orders the two luminances, forms the ratio numerator and denominator with
// the 0.05 offset, and decides the distinguishable flag.
// ----------------------------------------------------------------------------
module ccrc_merge
  import ccrc_pkg::*;
#(
  parameter int LUM_FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [LUM_FRAC_BITS:0]     fg_lum_i,
  input  logic [LUM_FRAC_BITS:0]     bg_lum_i,
  input  logic [LUM_FRAC_BITS:0]     min_diff_i,
  output logic [LUM_FRAC_BITS+4:0]   num_o,
  output logic [LUM_FRAC_BITS+4:0]   den_o,
  output logic [LUM_FRAC_BITS:0]     fg_lum_o,
  output logic [LUM_FRAC_BITS:0]     bg_lum_o,
  output logic                       dist_o
);

  localparam int LW = LUM_FRAC_BITS + 1;
  localparam int NW = LUM_FRAC_BITS + 5;
  localparam logic [NW-1:0] LUM_ONE = NW'(1) << LUM_FRAC_BITS;

  logic [LW-1:0] hi, lo, diff;
  logic [NW-1:0] num_q, den_q;
  logic [LW-1:0] fg_q, bg_q;
  logic          dist_q;

  assign hi   = (fg_lum_i > bg_lum_i) ? fg_lum_i : bg_lum_i;
  assign lo   = (fg_lum_i > bg_lum_i) ? bg_lum_i : fg_lum_i;
  assign diff = hi - lo;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= NW'(hi) * NW'(20) + LUM_ONE;
      den_q  <= NW'(lo) * NW'(20) + LUM_ONE;
      fg_q   <= fg_lum_i;
      bg_q   <= bg_lum_i;
      dist_q <= diff > min_diff_i;
    end
  end

  assign num_o    = num_q;
  assign den_o    = den_q;
  assign fg_lum_o = fg_q;
  assign bg_lum_o = bg_q;
  assign dist_o   = dist_q;

endmodule

@@ sv/ccrc_div_pipe.sv @@
// ----------------------------------------------------------------------------
// Ratio divider
// Pipelined restoring divider giving one quotient bit per stage for the
// 8-fraction-bit contrast ratio, with a side tag carried alongside.
// ----------------------------------------------------------------------------
module ccrc_div_pipe
  import ccrc_pkg::*;
#(
  parameter int NUM_W = 21,
  parameter int TAG_W = 35
) (
  input  logic              clk_i,
  input  logic [QUO_W-1:0]  en_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [NUM_W-1:0]  den_i,
  input  logic [TAG_W-1:0]  tag_i,
  output logic [QUO_W-1:0]  quo_o,
  output logic [TAG_W-1:0]  tag_o
);

  localparam int DVW = NUM_W + QUO_W;

  logic [DVW-1:0]   rem_q [QUO_W-1];
  logic [NUM_W-1:0] den_q [QUO_W-1];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [TAG_W-1:0] tag_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int B = QUO_W - 1 - k;

    logic [DVW-1:0]   rem_in, trial;
    logic [NUM_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [TAG_W-1:0] tag_in;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = DVW'(num_i) << RATIO_FRAC;
      assign den_in = den_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    assign trial = DVW'(den_in) << B;
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        quo_q[k] <= quo_in | (QUO_W'(ge) << B);
        tag_q[k] <= tag_in;
      end
    end

    if (k < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          rem_q[k] <= ge ? rem_in - trial : rem_in;
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];
  assign tag_o = tag_q[QUO_W-1];

endmodule

@@ sv/color_contrast_ratio_check.sv @@
// ----------------------------------------------------------------------------
// Colour contrast ratio check
// Computes both relative luminances of a colour pair, the contrast ratio and
// the pass and distinguishable flags.
// ----------------------------------------------------------------------------
// The block takes one foreground/background pair per clock cycle when the
// output is not stalled and passes it through eighteen register stages, the
// first loaded at the accepting edge: three stages in the two luminance
// lanes, one merge stage, thirteen stages of the one-bit-per-stage ratio
// divider and the output register. Stages advance independently, so gaps in
// the stream close up while the output is stalled.
// The configuration registers should only be written while no transaction is
// in flight.
module color_contrast_ratio_check
  import ccrc_pkg::*;
#(
  parameter int CHANNEL_BITS  = 8,
  parameter int LUM_FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [CHANNEL_BITS-1:0]   fg_red_i,
  input  logic [CHANNEL_BITS-1:0]   fg_green_i,
  input  logic [CHANNEL_BITS-1:0]   fg_blue_i,
  input  logic [CHANNEL_BITS-1:0]   bg_red_i,
  input  logic [CHANNEL_BITS-1:0]   bg_green_i,
  input  logic [CHANNEL_BITS-1:0]   bg_blue_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [LUM_FRAC_BITS:0]    fg_luminance_o,
  output logic [LUM_FRAC_BITS:0]    bg_luminance_o,
  output logic [RATIO_W-1:0]        contrast_ratio_q8_o,
  output logic                      meets_minimum_o,
  output logic                      distinguishable_o
);

  localparam int LW       = LUM_FRAC_BITS + 1;
  localparam int NW       = LUM_FRAC_BITS + 5;
  localparam int TAG_W    = 2 * LW + 1;
  localparam int ST_MERGE = 3;
  localparam int ST_DIV   = ST_MERGE + 1;
  localparam int NST      = ST_DIV + QUO_W + 1;
  localparam logic [LW-1:0] MIN_DIFF_RST = LW'((64'd1 << LUM_FRAC_BITS) / 64'd5);

  logic [RATIO_W-1:0] min_ratio_q;
  logic [LW-1:0]      min_diff_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_ratio_q <= MIN_RATIO_RST;
      min_diff_q  <= MIN_DIFF_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MIN_RATIO:    min_ratio_q <= pwdata[RATIO_W-1:0];
        REG_MIN_LUM_DIFF: min_diff_q  <= pwdata[LW-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MIN_RATIO:    prdata = DATA_W'(min_ratio_q);
      REG_MIN_LUM_DIFF: prdata = DATA_W'(min_diff_q);
      default:          prdata = '0;
    endcase
  end

  logic [NST-1:0] v_q, v_d, en, v_src;

  assign v_src = {v_q[NST-2:0], in_valid_i};

  always_comb begin
    en[NST-1] = !v_q[NST-1] || !out_stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    for (int k = 0; k < NST; k++) begin
      v_d[k] = en[k] ? v_src[k] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NST-1];

  logic [LW-1:0] fg_lum, bg_lum, m_fg, m_bg, t_fg, t_bg;
  logic [NW-1:0] m_num, m_den;
  logic          m_dist, t_dist;
  logic [QUO_W-1:0] quo;

  ccrc_lum_lane #(
    .CHANNEL_BITS  (CHANNEL_BITS),
    .LUM_FRAC_BITS (LUM_FRAC_BITS)
  ) u_fg_lane (
    .clk_i   (clk_i),
    .en_i    (en[ST_MERGE-1:0]),
    .red_i   (fg_red_i),
    .green_i (fg_green_i),
    .blue_i  (fg_blue_i),
    .lum_o   (fg_lum)
  );

  ccrc_lum_lane #(
    .CHANNEL_BITS  (CHANNEL_BITS),
    .LUM_FRAC_BITS (LUM_FRAC_BITS)
  ) u_bg_lane (
    .clk_i   (clk_i),
    .en_i    (en[ST_MERGE-1:0]),
    .red_i   (bg_red_i),
    .green_i (bg_green_i),
    .blue_i  (bg_blue_i),
    .lum_o   (bg_lum)
  );

  ccrc_merge #(
    .LUM_FRAC_BITS (LUM_FRAC_BITS)
  ) u_merge (
    .clk_i      (clk_i),
    .en_i       (en[ST_MERGE]),
    .fg_lum_i   (fg_lum),
    .bg_lum_i   (bg_lum),
    .min_diff_i (min_diff_q),
    .num_o      (m_num),
    .den_o      (m_den),
    .fg_lum_o   (m_fg),
    .bg_lum_o   (m_bg),
    .dist_o     (m_dist)
  );

  ccrc_div_pipe #(
    .NUM_W (NW),
    .TAG_W (TAG_W)
  ) u_div (
    .clk_i (clk_i),
    .en_i  (en[ST_DIV +: QUO_W]),
    .num_i (m_num),
    .den_i (m_den),
    .tag_i ({m_fg, m_bg, m_dist}),
    .quo_o (quo),
    .tag_o ({t_fg, t_bg, t_dist})
  );

  logic [LW-1:0]      out_fg_q, out_bg_q;
  logic [RATIO_W-1:0] out_ratio_q;
  logic               out_meets_q, out_dist_q;

  always_ff @(posedge clk_i) begin
    if (en[NST-1]) begin
      out_fg_q    <= t_fg;
      out_bg_q    <= t_bg;
      out_ratio_q <= RATIO_W'(quo);
      out_meets_q <= RATIO_W'(quo) >= min_ratio_q;
      out_dist_q  <= t_dist;
    end
  end

  assign fg_luminance_o      = out_fg_q;
  assign bg_luminance_o      = out_bg_q;
  assign contrast_ratio_q8_o = out_ratio_q;
  assign meets_minimum_o     = out_meets_q;
  assign distinguishable_o   = out_dist_q;

endmodule

@@ test/color_contrast_ratio_check_tb.sv @@
// ----------------------------------------------------------------------------
// Colour contrast ratio check testbench
// Streams foreground/background colour pairs into the block under random
// source gaps and sink stalls, and compares every result field against an
// independent luminance and contrast predictor. The predictor is kept in step
// with the threshold registers, which are written and read back over APB
// between phases.
// ----------------------------------------------------------------------------
module color_contrast_ratio_check_tb
  import ccrc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CH_BITS     = 8;
  localparam int          LUM_FRAC    = 16;
  localparam int          LUM_W       = LUM_FRAC + 1;
  localparam int          Q30         = 30;
  localparam logic [63:0] LUM_ONE     = 64'd1 << LUM_FRAC;
  localparam logic [63:0] WT_R        = 64'd13933;
  localparam logic [63:0] WT_G        = 64'd46871;
  localparam logic [63:0] WT_B        = 64'd4732;
  localparam int          LONG_HOLD   = 300;
  localparam int          BURST_LEN   = 80;
  localparam int          PHASES      = 12;
  localparam int          RANDOM_LEN  = 125;
  localparam int          CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [CH_BITS-1:0] fg_r, fg_g, fg_b, bg_r, bg_g, bg_b;
  } colour_pair_t;

  typedef struct packed {
    logic [LUM_W-1:0]   fg_lum;
    logic [LUM_W-1:0]   bg_lum;
    logic [RATIO_W-1:0] ratio;
    logic               meets;
    logic               distinct;
  } contrast_t;

  typedef struct packed {
    colour_pair_t pair;
    logic         typed;
    contrast_t    want;
  } stim_row_t;

  localparam int DIRECTED_LEN = 22;
  localparam stim_row_t DIRECTED [DIRECTED_LEN] = '{
    '{48'h000000_ffffff, 1'b1, '{17'd0, 17'd65536, 13'd5376, 1'b1, 1'b1}},
    '{48'hffffff_000000, 1'b1, '{17'd65536, 17'd0, 13'd5376, 1'b1, 1'b1}},
    '{48'h000000_000000, 1'b1, '{17'd0, 17'd0, 13'd256, 1'b0, 1'b0}},
    '{48'hffffff_ffffff, 1'b1, '{17'd65536, 17'd65536, 13'd256, 1'b0, 1'b0}},
    '{48'hff0000_000000, 1'b0, '0},
    '{48'h00ff00_000000, 1'b0, '0},
    '{48'h0000ff_000000, 1'b0, '0},
    '{48'h0000ff_ffffff, 1'b0, '0},
    '{48'h0a0a0a_0b0b0b, 1'b0, '0},
    '{48'h0b0b0b_0a0a0a, 1'b0, '0},
    '{48'h010203_fefdfc, 1'b0, '0},
    '{48'h808080_808080, 1'b0, '0},
    '{48'h767676_ffffff, 1'b0, '0},
    '{48'h777777_ffffff, 1'b0, '0},
    '{48'h595959_ffffff, 1'b0, '0},
    '{48'h0a0000_000b00, 1'b0, '0},
    '{48'h00000a_0b0000, 1'b0, '0},
    '{48'haaaaaa_555555, 1'b0, '0},
    '{48'hffffff_ff0000, 1'b0, '0},
    '{48'h123456_654321, 1'b0, '0},
    '{48'h000000_010101, 1'b0, '0},
    '{48'hfefefe_ffffff, 1'b0, '0}
  };

  localparam int PROBE_LEN = 6;
  localparam colour_pair_t PROBES [PROBE_LEN] = '{
    48'h000000_ffffff, 48'hffffff_000000, 48'hff0000_000000,
    48'h000000_ff0000, 48'h808080_808080, 48'h00ff00_000000
  };

  localparam logic [CH_BITS-1:0] PALETTE [8] = '{
    8'd0, 8'd1, 8'd10, 8'd11, 8'd127, 8'd128, 8'd254, 8'd255
  };

  localparam int unsigned RATIO_SET [7] = '{768, 0, 5376, 5377, 8191, 256, 1152};
  localparam int unsigned DIFF_SET  [7] = '{0, 65536, 65537, 131071, 13933, 13932, 13107};

  logic                clk;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [LUM_W-1:0]    fg_luminance_o;
  logic [LUM_W-1:0]    bg_luminance_o;
  logic [RATIO_W-1:0]  contrast_ratio_q8_o;
  logic                meets_minimum_o;
  logic                distinguishable_o;

  colour_pair_t        tx_pair;
  logic                tx_typed;
  contrast_t           tx_want;

  logic [LUM_W-1:0]    srgb_lin [1 << CH_BITS];
  logic [RATIO_W-1:0]  ratio_min_q8;
  logic [LUM_W-1:0]    lum_diff_min;
  contrast_t           pending_contrast [$];

  int unsigned         tx_mode;
  int unsigned         rx_mode;
  bit                  burst_on;
  int unsigned         hold_req;
  int unsigned         hold_done;
  int unsigned         mismatches;
  int unsigned         pairs_sent;
  int unsigned         results_seen;
  int unsigned         cycle_count;

  color_contrast_ratio_check u_dut (
    .clk_i               (clk),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .fg_red_i            (tx_pair.fg_r),
    .fg_green_i          (tx_pair.fg_g),
    .fg_blue_i           (tx_pair.fg_b),
    .bg_red_i            (tx_pair.bg_r),
    .bg_green_i          (tx_pair.bg_g),
    .bg_blue_i           (tx_pair.bg_b),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .fg_luminance_o      (fg_luminance_o),
    .bg_luminance_o      (bg_luminance_o),
    .contrast_ratio_q8_o (contrast_ratio_q8_o),
    .meets_minimum_o     (meets_minimum_o),
    .distinguishable_o   (distinguishable_o)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [63:0] q30_pow5(input logic [63:0] w);
    logic [63:0] p;
    p = w;
    repeat (4) p = (p * w) >> Q30;
    return p;
  endfunction

  function automatic logic [63:0] q30_root5(input logic [63:0] y2);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = 64'd0;
    hi = 64'd1 << Q30;
    while (lo < hi) begin
      mid = lo + (hi - lo + 64'd1) / 64'd2;
      if (q30_pow5(mid) <= y2) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  // Below the knee the sRGB curve is a straight line; above it the 2.4 power
  // is formed as a square times a fifth root, all in Q30.
  function automatic logic [LUM_W-1:0] srgb_to_linear(input logic [63:0] c);
    logic [63:0] m;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] y;
    logic [63:0] y2;
    m = (64'd1 << CH_BITS) - 64'd1;
    if (c * 64'd100000 <= 64'd3928 * m) begin
      den = 64'd1292 * m;
      return LUM_W'((((c * 64'd100) << LUM_FRAC) + den / 64'd2) / den);
    end
    num = 64'd1000 * c + 64'd55 * m;
    den = 64'd1055 * m;
    y   = ((num << Q30) + den / 64'd2) / den;
    y2  = (y * y + (64'd1 << (Q30 - 1))) >> Q30;
    return LUM_W'((y2 * q30_root5(y2) + (64'd1 << (2 * Q30 - 1 - LUM_FRAC)))
                  >> (2 * Q30 - LUM_FRAC));
  endfunction

  function automatic logic [63:0] luma_of(input logic [CH_BITS-1:0] r,
                                          input logic [CH_BITS-1:0] g,
                                          input logic [CH_BITS-1:0] b);
    logic [63:0] s;
    s = WT_R * 64'(srgb_lin[r]) + WT_G * 64'(srgb_lin[g]) + WT_B * 64'(srgb_lin[b]);
    return (s + 64'd32768) >> 16;
  endfunction

  function automatic contrast_t contrast_of(input colour_pair_t p);
    logic [63:0] lf;
    logic [63:0] lb;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] num;
    logic [63:0] den;
    contrast_t   r;
    lf         = luma_of(p.fg_r, p.fg_g, p.fg_b);
    lb         = luma_of(p.bg_r, p.bg_g, p.bg_b);
    hi         = (lf > lb) ? lf : lb;
    lo         = (lf > lb) ? lb : lf;
    num        = 64'd20 * hi + LUM_ONE;
    den        = 64'd20 * lo + LUM_ONE;
    r.fg_lum   = LUM_W'(lf);
    r.bg_lum   = LUM_W'(lb);
    r.ratio    = RATIO_W'((num << 8) / den);
    r.meets    = (num << 8) >= 64'(ratio_min_q8) * den;
    r.distinct = (hi - lo) > 64'(lum_diff_min);
    return r;
  endfunction

  function automatic logic [CH_BITS-1:0] palette_level();
    return PALETTE[$urandom_range(0, 7)];
  endfunction

  function automatic colour_pair_t pick_pair();
    colour_pair_t     p;
    logic [CH_BITS-1:0] g;
    logic [CH_BITS-1:0] h;
    p = 48'({$urandom(), $urandom()});
    g = CH_BITS'($urandom());
    h = CH_BITS'($urandom());
    case ($urandom_range(0, 9))
      0: begin
        p = {palette_level(), palette_level(), palette_level(),
             palette_level(), palette_level(), palette_level()};
      end
      1: begin
        p.bg_r = p.fg_r;
        p.bg_g = p.fg_g;
        p.bg_b = p.fg_b;
      end
      2: begin
        p.bg_r = p.fg_r ^ CH_BITS'($urandom_range(0, 3));
        p.bg_g = p.fg_g ^ CH_BITS'($urandom_range(0, 3));
        p.bg_b = p.fg_b ^ CH_BITS'($urandom_range(0, 3));
      end
      3: begin
        p = {g, g, g, h, h, h};
      end
      default: begin
      end
    endcase
    return p;
  endfunction

  function automatic int unsigned source_gap();
    if (burst_on || tx_mode == 1) begin
      return 0;
    end
    if (tx_mode == 2) begin
      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic int unsigned sink_wait();
    if (hold_req != hold_done) begin
      hold_done = hold_done + 1;
      return LONG_HOLD;
    end
    if (rx_mode == 1) begin
      return 0;
    end
    if (rx_mode == 2) begin
      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
    end
    return $urandom_range(0, 19);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches = mismatches + 1;
    if (mismatches <= 25) begin
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    end
  endtask

  task automatic apb_access(input logic wr, input reg_idx_e idx,
                            input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'(int'(idx) * 4);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
  endtask

  task automatic apb_idle();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_register(input reg_idx_e idx, input logic [DATA_W-1:0] want);
    logic [DATA_W-1:0] rdata;
    apb_access(1'b0, idx, DATA_W'($urandom()), rdata);
    if (rdata !== want) begin
      report_mismatch(idx == REG_MIN_RATIO ? "min_ratio_q8 readback"
                                           : "min_lum_difference readback", rdata, want);
    end
  endtask

  task automatic apply_settings(input int unsigned ratio, input int unsigned diff,
                                input bit junk_high);
    logic [DATA_W-1:0] rdata;
    logic [DATA_W-1:0] wr_ratio;
    logic [DATA_W-1:0] wr_diff;
    wr_ratio = DATA_W'(ratio);
    wr_diff  = DATA_W'(diff);
    if (junk_high) begin
      wr_ratio[DATA_W-1:RATIO_W] = (DATA_W - RATIO_W)'($urandom());
      wr_diff[DATA_W-1:LUM_W]    = (DATA_W - LUM_W)'($urandom());
    end
    apb_access(1'b1, REG_MIN_RATIO, wr_ratio, rdata);
    ratio_min_q8 = wr_ratio[RATIO_W-1:0];
    apb_access(1'b1, REG_MIN_LUM_DIFF, wr_diff, rdata);
    lum_diff_min = wr_diff[LUM_W-1:0];
    check_register(REG_MIN_RATIO, DATA_W'(ratio_min_q8));
    check_register(REG_MIN_LUM_DIFF, DATA_W'(lum_diff_min));
    apb_idle();
  endtask

  // Leaves valid high after acceptance; the caller either offers the next pair
  // in the same step or drops valid.
  task automatic offer_pair(input colour_pair_t p, input logic typed, input contrast_t want);
    int unsigned gap;
    gap = source_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tx_pair    <= p;
    tx_typed   <= typed;
    tx_want    <= want;
    in_valid_i <= 1'b1;
    do @(posedge clk); while (in_stall_o !== 1'b0);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk); while (pending_contrast.size() != 0);
  endtask

  always @(posedge clk) begin : scoreboard
    contrast_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen = results_seen + 1;
        if (pending_contrast.size() == 0) begin
          report_mismatch("result with no transaction pending", results_seen, 0);
        end else begin
          want = pending_contrast.pop_front();
          if (fg_luminance_o !== want.fg_lum) begin
            report_mismatch("fg_luminance", fg_luminance_o, want.fg_lum);
          end
          if (bg_luminance_o !== want.bg_lum) begin
            report_mismatch("bg_luminance", bg_luminance_o, want.bg_lum);
          end
          if (contrast_ratio_q8_o !== want.ratio) begin
            report_mismatch("contrast_ratio_q8", contrast_ratio_q8_o, want.ratio);
          end
          if (meets_minimum_o !== want.meets) begin
            report_mismatch("meets_minimum", meets_minimum_o, want.meets);
          end
          if (distinguishable_o !== want.distinct) begin
            report_mismatch("distinguishable", distinguishable_o, want.distinct);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        pairs_sent = pairs_sent + 1;
        pending_contrast.push_back(tx_typed ? tx_want : contrast_of(tx_pair));
      end
    end
  end

  initial begin : result_sink
    int unsigned stall_left;
    out_stall_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(posedge clk);
      if (out_stall_i) begin
        if (stall_left <= 1) begin
          out_stall_i <= 1'b0;
        end
        stall_left = stall_left - 1;
      end else if (rst_ni && out_valid_o) begin
        stall_left = sink_wait();
        if (stall_left > 0) begin
          out_stall_i <= 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count = cycle_count + 1;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycle_count, pending_contrast.size());
    $display("color_contrast_ratio_check_tb failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned ratio;
    int unsigned diff;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    tx_pair      = '0;
    tx_typed     = 1'b0;
    tx_want      = '0;
    tx_mode      = 0;
    rx_mode      = 0;
    burst_on     = 1'b0;
    hold_req     = 0;
    hold_done    = 0;
    mismatches   = 0;
    pairs_sent   = 0;
    results_seen = 0;
    ratio_min_q8 = 13'd1152;
    lum_diff_min = 17'd13107;
    for (int c = 0; c < (1 << CH_BITS); c++) begin
      srgb_lin[c] = srgb_to_linear(64'(c));
    end
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    check_register(REG_MIN_RATIO, DATA_W'(ratio_min_q8));
    check_register(REG_MIN_LUM_DIFF, DATA_W'(lum_diff_min));
    apb_idle();
    for (int i = 0; i < DIRECTED_LEN; i++) begin
      offer_pair(DIRECTED[i].pair, DIRECTED[i].typed, DIRECTED[i].want);
    end
    wait_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 7) begin
        ratio = RATIO_SET[phase];
        diff  = DIFF_SET[phase];
      end else begin
        ratio = $urandom_range(0, 1) ? $urandom_range(256, 5376) : $urandom_range(0, 8191);
        diff  = $urandom_range(0, 1) ? $urandom_range(0, 65536) : $urandom_range(0, 131071);
      end
      apply_settings(ratio, diff, phase % 3 == 2);
      tx_mode = phase % 3;
      rx_mode = (phase / 3) % 3;
      if (phase == 1) begin
        hold_req = hold_req + 1;
      end
      for (int k = 0; k < PROBE_LEN; k++) begin
        offer_pair(PROBES[k], 1'b0, '0);
      end
      if (phase == 1) begin
        burst_on = 1'b1;
        repeat (BURST_LEN) offer_pair(pick_pair(), 1'b0, '0);
        burst_on = 1'b0;
      end
      for (int k = 0; k < RANDOM_LEN; k++) begin
        offer_pair(pick_pair(), 1'b0, '0);
        if ($urandom_range(0, 63) == 0) begin
          wait_drained();
        end
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (pending_contrast.size() != 0) begin
      report_mismatch("results never returned", pending_contrast.size(), 0);
    end
    $display("Checked %0d of %0d colour pairs over %0d threshold settings, %0d mismatches.",
             results_seen, pairs_sent, PHASES + 1, mismatches);
    if (mismatches == 0) begin
      $display("color_contrast_ratio_check_tb passed");
    end else begin
      $display("color_contrast_ratio_check_tb failed");
    end
    $finish;
  end

endmodule

@@ color_contrast_ratio_check.f @@
sv/ccrc_pkg.sv
sv/ccrc_lum_lane.sv
sv/ccrc_merge.sv
sv/ccrc_div_pipe.sv
sv/color_contrast_ratio_check.sv
test/color_contrast_ratio_check_tb.sv
